>>> src/rmlp_pkg.sv
// Shared types and constants of the RTP MIDI list parser.
`timescale 1ns / 1ps

package rmlp_pkg;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PTYPE     = 3'd1;
  localparam logic [2:0] ERR_SSRC      = 3'd2;
  localparam logic [2:0] ERR_DATA      = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  localparam logic [6:0] PAYLOAD_TYPE = 7'h61;

  // One decoded result.
  typedef struct packed {
    logic [7:0] midi_byte;
    logic       msg_first;
    logic       msg_last;
    logic       sysex_fragment;
    logic [2:0] error_code;
  } res_t;

  // Results caused by one packet byte: r0 always, r1 when two is set.
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

endpackage

>>> src/rtp_midi_list_parser_core.sv
// Top level of the RTP MIDI list parser.
`timescale 1ns / 1ps

// Takes an RTP MIDI packet one byte per cycle and returns the MIDI bytes of its
// command list, with first/last marks, SysEx fragment marks and error codes.
// in_ready stays high while the result queue has room, so a byte is taken every
// cycle. Each byte yields zero, one or two results; the back end sends one
// result per cycle while out_ready is high, so a byte whose running status is
// put back in front gives two results, and a queue of QUEUE_DEPTH bundles
// absorbs such bursts. A byte's bundle is written into the queue and from
// there loaded into the output register that drives out_valid.
// cfg_wr_data is the expected SSRC; write it only while the block is idle.
module rtp_midi_list_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  input  logic        in_packet_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_midi_byte,
  output logic        out_msg_first,
  output logic        out_msg_last,
  output logic        out_sysex_fragment,
  output logic [2:0]  out_error_code
);

  logic [31:0]       ssrc_cfg_r;
  logic              byte_vld;
  logic              push, pop, q_empty, q_full;
  rmlp_pkg::bundle_t push_data, head;
  rmlp_pkg::res_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssrc_cfg_r <= 32'd0;
    end else if (cfg_wr_en) begin
      ssrc_cfg_r <= cfg_wr_data;
    end
  end

  assign in_ready = !q_full;
  assign byte_vld = in_valid && in_ready;

  rmlp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .expected_ssrc(ssrc_cfg_r),
    .byte_vld     (byte_vld),
    .data_byte    (in_data_byte),
    .packet_start (in_packet_start),
    .packet_end   (in_packet_end),
    .push         (push),
    .push_data    (push_data)
  );

  rmlp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rmlp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_midi_byte      = out_res.midi_byte;
  assign out_msg_first      = out_res.msg_first;
  assign out_msg_last       = out_res.msg_last;
  assign out_sysex_fragment = out_res.sysex_fragment;
  assign out_error_code     = out_res.error_code;

endmodule

>>> src/rmlp_front.sv
// Front end: packet header check, MIDI list walk, result bundle generation.
`timescale 1ns / 1ps

module rmlp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      expected_ssrc,
  input  logic             byte_vld,
  input  logic [7:0]       data_byte,
  input  logic             packet_start,
  input  logic             packet_end,
  output logic             push,
  output rmlp_pkg::bundle_t push_data
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_HDR   = 3'd1;
  localparam logic [2:0] PH_LENLO = 3'd2;
  localparam logic [2:0] PH_DELTA = 3'd3;
  localparam logic [2:0] PH_START = 3'd4;
  localparam logic [2:0] PH_BODY  = 3'd5;
  localparam logic [2:0] PH_SYSEX = 3'd6;
  localparam logic [2:0] PH_TAIL  = 3'd7;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  hcount_r, hcount_nxt;
  logic [11:0] lrem_r, lrem_nxt;
  logic [1:0]  mrem_r, mrem_nxt;
  logic [7:0]  rstat_r, rstat_nxt;
  logic [31:0] ssrc_r, ssrc_nxt;
  logic        insx_r, insx_nxt;
  logic        bad_r, bad_nxt;

  logic [1:0]  nres;
  rmlp_pkg::res_t res0, res1;

  function automatic logic [1:0] voice_len(input logic [7:0] st);
    voice_len = (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd2 : 2'd3;
  endfunction

  function automatic rmlp_pkg::res_t mk(input logic [7:0] b, input logic first,
                                        input logic last, input logic frag);
    rmlp_pkg::res_t r;
    r.midi_byte      = b;
    r.msg_first      = first;
    r.msg_last       = last;
    r.sysex_fragment = frag;
    r.error_code     = rmlp_pkg::ERR_NONE;
    mk = r;
  endfunction

  always_comb begin
    logic [2:0]  ph;
    logic [3:0]  hc;
    logic [11:0] lr;
    logic [1:0]  mr;
    logic [7:0]  rs;
    logic [31:0] ss;
    logic        ix;
    logic        bd;
    logic [2:0]  fcode;
    logic        done;
    logic        hdr_go;
    logic        sl_go;
    logic        sl_z;
    logic [1:0]  len;
    logic        frag;
    logic [7:0]  b;

    ph = phase_r; hc = hcount_r; lr = lrem_r; mr = mrem_r;
    rs = rstat_r; ss = ssrc_r; ix = insx_r; bd = bad_r;
    fcode = rmlp_pkg::ERR_NONE;
    done = 1'b0; hdr_go = 1'b0; sl_go = 1'b0; sl_z = 1'b0;
    len = 2'd0; frag = 1'b0;
    b = data_byte;
    nres = 2'd0;
    res0 = '0;
    res1 = '0;

    if (packet_start) begin
      ph = PH_HDR; hc = 4'd0; lr = 12'd0; mr = 2'd0; bd = 1'b0;
    end

    if (!bd) begin
      case (ph)
        PH_HDR: begin
          hdr_go = 1'b1;
          if (hc == 4'd1 && b[6:0] != rmlp_pkg::PAYLOAD_TYPE) begin
            fcode = rmlp_pkg::ERR_PTYPE;
            hdr_go = 1'b0;
          end else if (hc inside {[4'd8:4'd11]}) begin
            ss = {ss[23:0], b};
            if (hc == 4'd11 && ss != expected_ssrc) begin
              fcode = rmlp_pkg::ERR_SSRC;
              hdr_go = 1'b0;
            end
          end
          if (hdr_go) begin
            if (hc < 4'd12) begin
              hc = hc + 4'd1;
            end else if (b[7]) begin
              // long header: length high nibble now, low byte next
              lr = {b[3:0], 8'h00};
              hc = b[5] ? 4'd13 : 4'd12;
              ph = PH_LENLO;
            end else begin
              lr = {8'h00, b[3:0]};
              sl_go = 1'b1;
              sl_z = b[5];
            end
          end
        end
        PH_LENLO: begin
          lr = lr | {4'h0, b};
          sl_go = 1'b1;
          sl_z = (hc == 4'd13);
        end
        PH_DELTA, PH_START, PH_BODY, PH_SYSEX: begin
          lr = lr - 12'd1;
          case (ph)
            PH_DELTA: begin
              if (!b[7]) ph = PH_START;
            end
            PH_START: begin
              if (!b[7]) begin
                if (rs == 8'h00) begin
                  fcode = rmlp_pkg::ERR_DATA;
                end else begin
                  // abbreviated message: put the running status back in front
                  len = voice_len(rs);
                  res0 = mk(rs, 1'b1, 1'b0, 1'b0);
                  res1 = mk(b, 1'b0, len == 2'd2, 1'b0);
                  nres = 2'd2;
                  mr = len - 2'd2;
                  if (mr == 2'd0) done = 1'b1;
                  else ph = PH_BODY;
                end
              end else if (b < 8'hF0) begin
                rs = b;
                res0 = mk(b, 1'b1, 1'b0, 1'b0);
                nres = 2'd1;
                mr = voice_len(b) - 2'd1;
                ph = PH_BODY;
              end else if (b inside {8'hF0, 8'hF7, 8'hF4}) begin
                rs = 8'h00;
                ix = (b != 8'hF0);
                res0 = mk(b, 1'b1, 1'b0, ix);
                nres = 2'd1;
                ph = PH_SYSEX;
              end else if (b inside {8'hF5, 8'hFD}) begin
                fcode = rmlp_pkg::ERR_DATA;
              end else begin
                if (b == 8'hF1 || b == 8'hF3) len = 2'd2;
                else if (b == 8'hF2) len = 2'd3;
                else len = 2'd1;
                if (b < 8'hF8) rs = 8'h00;
                res0 = mk(b, 1'b1, len == 2'd1, 1'b0);
                nres = 2'd1;
                mr = len - 2'd1;
                if (mr == 2'd0) done = 1'b1;
                else ph = PH_BODY;
              end
            end
            PH_BODY: begin
              mr = mr - 2'd1;
              res0 = mk(b, 1'b0, mr == 2'd0, 1'b0);
              nres = 2'd1;
              if (mr == 2'd0) done = 1'b1;
            end
            default: begin
              if (!b[7]) begin
                res0 = mk(b, 1'b0, 1'b0, ix);
              end else begin
                if (b == 8'hF7) begin
                  frag = ix; ix = 1'b0;
                end else if (b == 8'hF0) begin
                  frag = 1'b1; ix = 1'b1;
                end else begin
                  frag = 1'b1; ix = 1'b0;
                end
                res0 = mk(b, 1'b0, 1'b1, frag);
                done = 1'b1;
              end
              nres = 2'd1;
            end
          endcase
          if (fcode == rmlp_pkg::ERR_NONE) begin
            if (done) ph = (lr != 12'd0) ? PH_DELTA : PH_TAIL;
            else if (lr == 12'd0) fcode = rmlp_pkg::ERR_TRUNCATED;
          end
        end
        default: begin
        end
      endcase
      if (sl_go) begin
        rs = 8'h00;
        mr = 2'd0;
        if (lr == 12'd0) ph = PH_TAIL;
        else ph = sl_z ? PH_DELTA : PH_START;
      end
    end

    if (fcode != rmlp_pkg::ERR_NONE) begin
      bd = 1'b1;
      ph = PH_IDLE;
    end

    if (packet_end) begin
      if (!bd && ph != PH_IDLE && ph != PH_TAIL) begin
        fcode = rmlp_pkg::ERR_TRUNCATED;
        bd = 1'b1;
      end
      ph = PH_IDLE;
    end

    // error goes on the last result of the byte, or in a result of its own
    if (fcode != rmlp_pkg::ERR_NONE) begin
      if (nres == 2'd0) begin
        res0.error_code = fcode;
        nres = 2'd1;
      end else if (nres == 2'd1) begin
        res0.error_code = fcode;
      end else begin
        res1.error_code = fcode;
      end
    end

    phase_nxt = ph; hcount_nxt = hc; lrem_nxt = lr; mrem_nxt = mr;
    rstat_nxt = rs; ssrc_nxt = ss; insx_nxt = ix; bad_nxt = bd;
  end

  assign push           = byte_vld && (nres != 2'd0);
  assign push_data.two  = (nres == 2'd2);
  assign push_data.r0   = res0;
  assign push_data.r1   = res1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hcount_r <= 4'd0;
      lrem_r   <= 12'd0;
      mrem_r   <= 2'd0;
      rstat_r  <= 8'h00;
      ssrc_r   <= 32'd0;
      insx_r   <= 1'b0;
      bad_r    <= 1'b0;
    end else if (byte_vld) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      lrem_r   <= lrem_nxt;
      mrem_r   <= mrem_nxt;
      rstat_r  <= rstat_nxt;
      ssrc_r   <= ssrc_nxt;
      insx_r   <= insx_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

>>> src/rmlp_queue.sv
// Small FIFO of result bundles between front end and back end.
`timescale 1ns / 1ps

module rmlp_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rmlp_pkg::bundle_t push_data,
  input  logic              pop,
  output rmlp_pkg::bundle_t head,
  output logic              empty,
  output logic              full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  rmlp_pkg::bundle_t mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
    if (do_pop)  rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule

>>> src/rmlp_back.sv
// Back end: unpacks bundles and drives the result channel, one result per cycle while out_ready is high.
`timescale 1ns / 1ps

module rmlp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rmlp_pkg::bundle_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rmlp_pkg::res_t    out_res
);

  rmlp_pkg::bundle_t cur_r, cur_nxt;
  logic              sel_r, sel_nxt;
  logic              vld_r, vld_nxt;
  logic              need;

  // a new bundle is needed when nothing is held, or the last result of it leaves
  assign need = !vld_r || (out_ready && (sel_r || !cur_r.two));
  assign pop  = need && !empty;

  always_comb begin
    cur_nxt = cur_r;
    sel_nxt = sel_r;
    vld_nxt = vld_r;
    if (need) begin
      vld_nxt = !empty;
      sel_nxt = 1'b0;
      if (!empty) cur_nxt = head;
    end else if (out_ready) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign out_valid = vld_r;
  assign out_res   = sel_r ? cur_r.r1 : cur_r.r0;

endmodule

>>> src/rmlp_checker.sv
// Port-level checks of the RTP MIDI list parser, bound to the top level.
`timescale 1ns / 1ps

module rmlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_midi_byte,
  input logic       out_msg_first,
  input logic [2:0] out_error_code
);

  // reset empties the output side
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= rmlp_pkg::ERR_TRUNCATED)
    else $error("error code out of range");

  // a message always opens with a status byte, reinserted ones included
  a_first_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_first |-> out_midi_byte[7])
    else $error("message opens with a data byte");

endmodule

bind rtp_midi_list_parser_core rmlp_checker u_rmlp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_midi_byte (out_midi_byte),
  .out_msg_first (out_msg_first),
  .out_error_code(out_error_code)
);

>>> tb/rtp_midi_list_parser_core_tb.sv
// Self-checking testbench for the RTP MIDI list parser core.
`timescale 1ns / 1ps

module rtp_midi_list_parser_core_tb;

  // MIDI status bytes with special handling
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] MTC_QFRAME    = 8'hF1;
  localparam logic [7:0] SONG_POSITION = 8'hF2;
  localparam logic [7:0] SONG_SELECT   = 8'hF3;
  localparam logic [7:0] SYSEX_CANCEL  = 8'hF4;
  localparam logic [7:0] UNDEF_F5      = 8'hF5;
  localparam logic [7:0] TUNE_REQUEST  = 8'hF6;
  localparam logic [7:0] SYSEX_END     = 8'hF7;
  localparam logic [7:0] REALTIME_LO   = 8'hF8;
  localparam logic [7:0] UNDEF_FD      = 8'hFD;
  localparam int         HDR_LAST      = 11;  // last RTP header byte index

  typedef enum logic [2:0] {
    PH_WAIT, PH_HEADER, PH_LEN_LO, PH_DELTA, PH_STATUS, PH_BODY, PH_SYSEX, PH_JOURNAL
  } parse_phase_e;

  typedef enum int {
    PKT_GOOD, PKT_BAD_TYPE, PKT_BAD_SSRC, PKT_LEN_TOO_LARGE, PKT_LEN_TOO_SMALL,
    PKT_RANDOM_LIST
  } pkt_kind_e;

  typedef logic [7:0] pkt_bytes_t[$];

  class midi_list_scoreboard;
    logic [31:0]    peer_ssrc = 32'h0;
    parse_phase_e   phase = PH_WAIT;
    logic [3:0]     hdr_count = 4'd0;
    logic [11:0]    list_left = 12'd0;
    logic [1:0]     body_left = 2'd0;
    logic [7:0]     run_status = 8'h00;
    logic [31:0]    ssrc_word = 32'h0;
    logic           sysex_cont = 1'b0;
    logic           pkt_dropped = 1'b0;
    rmlp_pkg::res_t step_out[$];
    rmlp_pkg::res_t pending_midi[$];
    int             errors = 0;

    function void push_res(logic [7:0] b, logic first, logic last, logic frag,
                           logic [2:0] err);
      rmlp_pkg::res_t r;
      r = '{midi_byte: b, msg_first: first, msg_last: last, sysex_fragment: frag,
            error_code: err};
      if (step_out.size() < 2) step_out.insert(step_out.size(), r);
    endfunction

    // error goes on the last result of this byte, else into an error-only result
    function void flag_error(logic [2:0] code);
      rmlp_pkg::res_t r;
      if (step_out.size() == 0) begin
        push_res(8'h00, 1'b0, 1'b0, 1'b0, code);
      end else begin
        r = step_out.pop_back();
        if (r.error_code == rmlp_pkg::ERR_NONE) r.error_code = code;
        step_out.insert(step_out.size(), r);
      end
      pkt_dropped = 1'b1;
      phase = PH_WAIT;
    endfunction

    function logic [1:0] voice_length(logic [7:0] st);
      return (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd2 : 2'd3;
    endfunction

    function void open_list(logic z);
      run_status = 8'h00;
      body_left = 2'd0;
      if (list_left == 0) phase = PH_JOURNAL;
      else phase = z ? PH_DELTA : PH_STATUS;
    endfunction

    function void header_byte(logic [7:0] b);
      if (hdr_count == 1 && b[6:0] != rmlp_pkg::PAYLOAD_TYPE) begin
        flag_error(rmlp_pkg::ERR_PTYPE);
        return;
      end
      if (hdr_count >= 8 && hdr_count <= HDR_LAST) begin
        ssrc_word = {ssrc_word[23:0], b};
        if (hdr_count == HDR_LAST && ssrc_word != peer_ssrc) begin
          flag_error(rmlp_pkg::ERR_SSRC);
          return;
        end
      end
      if (hdr_count <= HDR_LAST) begin
        hdr_count = hdr_count + 4'd1;
        return;
      end
      list_left = {8'h00, b[3:0]};
      if (b[7]) begin
        list_left = {b[3:0], 8'h00};
        hdr_count = b[5] ? 4'd13 : 4'd12;  // remember Z for the long form
        phase = PH_LEN_LO;
      end else begin
        open_list(b[5]);
      end
    endfunction

    function void list_byte(logic [7:0] b);
      logic       done;
      logic       frag;
      logic [1:0] len;
      done = 1'b0;
      list_left = list_left - 12'd1;
      case (phase)
        PH_DELTA: begin
          if (!b[7]) phase = PH_STATUS;
        end
        PH_STATUS: begin
          if (!b[7]) begin
            if (run_status == 0) begin
              flag_error(rmlp_pkg::ERR_DATA);
              return;
            end
            // abbreviated message: put the running status back in front
            len = voice_length(run_status);
            push_res(run_status, 1'b1, 1'b0, 1'b0, rmlp_pkg::ERR_NONE);
            push_res(b, 1'b0, len == 2'd2, 1'b0, rmlp_pkg::ERR_NONE);
            body_left = len - 2'd2;
            if (body_left == 0) done = 1'b1;
            else phase = PH_BODY;
          end else if (b < SYSEX_START) begin
            run_status = b;
            push_res(b, 1'b1, 1'b0, 1'b0, rmlp_pkg::ERR_NONE);
            body_left = voice_length(b) - 2'd1;
            phase = PH_BODY;
          end else if (b == SYSEX_START || b == SYSEX_END || b == SYSEX_CANCEL) begin
            run_status = 8'h00;
            sysex_cont = (b != SYSEX_START);
            push_res(b, 1'b1, 1'b0, sysex_cont, rmlp_pkg::ERR_NONE);
            phase = PH_SYSEX;
          end else if (b == UNDEF_F5 || b == UNDEF_FD) begin
            flag_error(rmlp_pkg::ERR_DATA);
            return;
          end else begin
            if (b == MTC_QFRAME || b == SONG_SELECT) len = 2'd2;
            else if (b == SONG_POSITION) len = 2'd3;
            else len = 2'd1;
            if (b < REALTIME_LO) run_status = 8'h00;
            push_res(b, 1'b1, len == 2'd1, 1'b0, rmlp_pkg::ERR_NONE);
            body_left = len - 2'd1;
            if (body_left == 0) done = 1'b1;
            else phase = PH_BODY;
          end
        end
        PH_BODY: begin
          body_left = body_left - 2'd1;
          push_res(b, 1'b0, body_left == 0, 1'b0, rmlp_pkg::ERR_NONE);
          if (body_left == 0) done = 1'b1;
        end
        default: begin
          if (!b[7]) begin
            push_res(b, 1'b0, 1'b0, sysex_cont, rmlp_pkg::ERR_NONE);
          end else begin
            if (b == SYSEX_END) begin
              frag = sysex_cont;
              sysex_cont = 1'b0;
            end else if (b == SYSEX_START) begin
              frag = 1'b1;
              sysex_cont = 1'b1;
            end else begin
              frag = 1'b1;
              sysex_cont = 1'b0;
            end
            push_res(b, 1'b0, 1'b1, frag, rmlp_pkg::ERR_NONE);
            done = 1'b1;
          end
        end
      endcase
      if (done) phase = (list_left != 0) ? PH_DELTA : PH_JOURNAL;
      else if (list_left == 0) flag_error(rmlp_pkg::ERR_TRUNCATED);
    endfunction

    // one accepted input transaction
    function void note_byte(logic [7:0] b, logic first, logic last);
      step_out.delete();
      if (first) begin
        phase = PH_HEADER;
        hdr_count = 4'd0;
        list_left = 12'd0;
        body_left = 2'd0;
        pkt_dropped = 1'b0;
      end
      if (!pkt_dropped) begin
        case (phase)
          PH_HEADER: header_byte(b);
          PH_LEN_LO: begin
            list_left = list_left | {4'h0, b};
            open_list(hdr_count == 4'd13);
          end
          PH_DELTA, PH_STATUS, PH_BODY, PH_SYSEX: list_byte(b);
          default: ;
        endcase
      end
      if (last) begin
        if (!pkt_dropped && phase != PH_WAIT && phase != PH_JOURNAL)
          flag_error(rmlp_pkg::ERR_TRUNCATED);
        phase = PH_WAIT;
      end
      foreach (step_out[i]) pending_midi.insert(pending_midi.size(), step_out[i]);
    endfunction

    function void match_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rmlp_pkg::res_t got);
      rmlp_pkg::res_t want;
      if (pending_midi.size() == 0) begin
        $error("result with nothing pending: midi_byte %0h error_code %0d",
               got.midi_byte, got.error_code);
        errors++;
        return;
      end
      want = pending_midi.pop_front();
      match_field("midi_byte", want.midi_byte, got.midi_byte);
      match_field("msg_first", want.msg_first, got.msg_first);
      match_field("msg_last", want.msg_last, got.msg_last);
      match_field("sysex_fragment", want.sysex_fragment, got.sysex_fragment);
      match_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_packet_start = 1'b0;
  logic        in_packet_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_midi_byte;
  logic        out_msg_first;
  logic        out_msg_last;
  logic        out_sysex_fragment;
  logic [2:0]  out_error_code;

  midi_list_scoreboard sb;
  int   burst_left;
  bit   steady_send;
  int   sent_count;
  int   rx_mode;
  int   rx_span;
  int   rx_cycle;

  rtp_midi_list_parser_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_packet_start    (in_packet_start),
    .in_packet_end      (in_packet_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_midi_byte      (out_midi_byte),
    .out_msg_first      (out_msg_first),
    .out_msg_last       (out_msg_last),
    .out_sysex_fragment (out_sysex_fragment),
    .out_error_code     (out_error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // transaction monitor for both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_byte(in_data_byte, in_packet_start, in_packet_end);
    if (rst_n && out_valid && out_ready)
      sb.check_result(rmlp_pkg::res_t'({out_midi_byte, out_msg_first, out_msg_last,
                                        out_sysex_fragment, out_error_code}));
  end

  // receiver: always ready, light random, periodic or heavy stalls
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(40, 300);
    end
    rx_span--;
    rx_cycle++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (rx_cycle % 8) > 2;
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    if (burst_left == 0) begin
      if (!steady_send && $urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_packet_start <= first;
    in_packet_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_packet(input pkt_bytes_t p, input bit close);
    foreach (p[i]) send_byte(p[i], i == 0, close && i == p.size() - 1);
  endtask

  // only while idle: drain results, let the pipeline settle, then write
  task automatic write_ssrc(input logic [31:0] value);
    in_valid <= 1'b0;
    while (sb.pending_midi.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.peer_ssrc = value;
  endtask

  function automatic void add_data(ref pkt_bytes_t lst, input int n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        lst.insert(lst.size(), 8'($urandom_range(8'h80, 8'hFF)));
      else lst.insert(lst.size(), 8'($urandom_range(0, 8'h7F)));
    end
  endfunction

  // mostly well-formed MIDI list; tracks running status like a sender would
  function automatic void gen_midi_list(ref pkt_bytes_t lst, input logic z);
    int         n_msg;
    int         pick;
    logic [7:0] gen_status;
    logic [7:0] st;
    lst.delete();
    gen_status = 8'h00;
    n_msg = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
    for (int i = 0; i < n_msg; i++) begin
      if (i > 0 || z) begin
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
          lst.insert(lst.size(), 8'h80 | 8'($urandom_range(0, 8'h7F)));
        lst.insert(lst.size(), 8'($urandom_range(0, 8'h7F)));
      end
      pick = $urandom_range(0, 99);
      if (pick < 55 && gen_status == 0 && $urandom_range(0, 4) != 0) pick = 0;
      if (pick < 35) begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        gen_status = st;
        lst.insert(lst.size(), st);
        add_data(lst, (st[7:5] == 3'b110) ? 1 : 2);
      end else if (pick < 55) begin
        add_data(lst, (gen_status[7:5] == 3'b110) ? 1 : 2);
      end else if (pick < 70) begin
        case ($urandom_range(0, 8))
          0, 1: begin lst.insert(lst.size(), MTC_QFRAME); add_data(lst, 1); end
          2, 3: begin lst.insert(lst.size(), SONG_POSITION); add_data(lst, 2); end
          4, 5: begin lst.insert(lst.size(), SONG_SELECT); add_data(lst, 1); end
          6, 7: lst.insert(lst.size(), TUNE_REQUEST);
          default: lst.insert(lst.size(), UNDEF_F5);
        endcase
        gen_status = 8'h00;
      end else if (pick < 80) begin
        lst.insert(lst.size(), 8'($urandom_range(REALTIME_LO, 8'hFF)));
      end else begin
        case ($urandom_range(0, 4))
          0, 1, 2: lst.insert(lst.size(), SYSEX_START);
          3: lst.insert(lst.size(), SYSEX_END);
          default: lst.insert(lst.size(), SYSEX_CANCEL);
        endcase
        repeat ($urandom_range(0, 6)) lst.insert(lst.size(), 8'($urandom_range(0, 8'h7F)));
        case ($urandom_range(0, 9))
          0: lst.insert(lst.size(), SYSEX_START);
          1: lst.insert(lst.size(), SYSEX_CANCEL);
          2: lst.insert(lst.size(), 8'($urandom_range(8'h80, 8'hFF)));
          default: lst.insert(lst.size(), SYSEX_END);
        endcase
        gen_status = 8'h00;
      end
    end
  endfunction

  function automatic void build_packet(ref pkt_bytes_t pkt, input pkt_kind_e kind,
                                      input logic [31:0] ssrc);
    pkt_bytes_t  lst;
    logic [11:0] len;
    logic [6:0]  ptype;
    logic [31:0] src_id;
    logic        z;
    logic        long_hdr;
    pkt.delete();
    ptype = rmlp_pkg::PAYLOAD_TYPE;
    if (kind == PKT_BAD_TYPE) ptype = rmlp_pkg::PAYLOAD_TYPE ^ 7'($urandom_range(1, 127));
    src_id = ssrc;
    if (kind == PKT_BAD_SSRC)
      src_id = $urandom_range(0, 1) ? ssrc ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
    pkt.insert(pkt.size(), 8'($urandom));
    pkt.insert(pkt.size(), {1'($urandom), ptype});
    repeat (6) pkt.insert(pkt.size(), 8'($urandom));
    for (int i = 3; i >= 0; i--) pkt.insert(pkt.size(), src_id[8*i +: 8]);
    z = 1'($urandom);
    if (kind == PKT_RANDOM_LIST) begin
      repeat ($urandom_range(1, 20)) lst.insert(lst.size(), 8'($urandom));
    end else if ($urandom_range(0, 15) != 0) begin
      gen_midi_list(lst, z);
    end
    len = 12'(lst.size());
    if (kind == PKT_LEN_TOO_LARGE)
      len = ($urandom_range(0, 3) == 0) ? 12'hFFF : len + 12'($urandom_range(1, 4));
    else if (kind == PKT_LEN_TOO_SMALL && lst.size() > 1)
      len = 12'($urandom_range(1, lst.size() - 1));
    long_hdr = (len > 15) || ($urandom_range(0, 3) == 0);
    if (long_hdr) begin
      pkt.insert(pkt.size(), {1'b1, 1'($urandom), z, 1'($urandom), len[11:8]});
      pkt.insert(pkt.size(), len[7:0]);
    end else begin
      pkt.insert(pkt.size(), {1'b0, 1'($urandom), z, 1'($urandom), len[3:0]});
    end
    foreach (lst[i]) pkt.insert(pkt.size(), lst[i]);
    // journal bytes; none when the list must end short
    if (kind != PKT_LEN_TOO_LARGE)
      repeat ($urandom_range(0, 4)) pkt.insert(pkt.size(), 8'($urandom));
  endfunction

  initial begin
    pkt_bytes_t  pkt;
    pkt_kind_e   kind;
    logic [31:0] ssrc_now;
    int          pick;
    int          phase_end;
    sb = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray byte, wrong payload type, a valid list with running
    // status (SSRC still at its reset value) and a one-byte packet
    send_byte(8'hFF, 1'b0, 1'b0);
    send_packet('{8'h80, 8'hE0, 8'h00}, 1'b1);
    send_packet('{8'h80, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'hC5, 8'h12, 8'h00, 8'h33}, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ssrc_now = 32'hFFFF_FFFF;
        2: ssrc_now = 32'h0000_0000;
        4: ssrc_now = 32'h8000_0001;
        default: ssrc_now = $urandom;
      endcase
      write_ssrc(ssrc_now);
      steady_send = (ph == 3);
      phase_end = sent_count + 275;
      while (sent_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) kind = PKT_GOOD;
        else if (pick < 66) kind = PKT_BAD_TYPE;
        else if (pick < 72) kind = PKT_BAD_SSRC;
        else if (pick < 78) kind = PKT_LEN_TOO_LARGE;
        else if (pick < 84) kind = PKT_LEN_TOO_SMALL;
        else kind = PKT_RANDOM_LIST;
        if (pick < 90) begin
          build_packet(pkt, kind, ssrc_now);
          send_packet(pkt, 1'b1);
        end else if (pick < 95) begin
          // packet cut short by the next start
          build_packet(pkt, PKT_GOOD, ssrc_now);
          pkt = pkt[0 : $urandom_range(0, pkt.size() - 2)];
          send_packet(pkt, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 1'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_midi.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/rmlp_pkg.sv
src/rmlp_front.sv
src/rmlp_queue.sv
src/rmlp_back.sv
src/rtp_midi_list_parser_core.sv
src/rmlp_checker.sv
tb/rtp_midi_list_parser_core_tb.sv
